// ----- hw/rtl/sat_pkg.sv -----
// Shared types, widths and helpers for the separating-axis MTV tracker.
`timescale 1ns / 1ps

package sat_pkg;

   localparam int COORD_W    = 32;
   localparam int LEN_W      = 64;
   localparam int DIVIDEND_W = 79;
   localparam int QUOT_W     = 32;

   // Status of the shared divider as seen by the sequencer
   typedef struct packed {
      logic done;
      logic capped;
   } div_stat_type;

   function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] v);
      return v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
   endfunction

endpackage

// ----- hw/rtl/sat_mul.sv -----
// Shared 32 x 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module sat_mul (
   input  logic                             clock,
   input  logic [sat_pkg::COORD_W-1:0]      op_a,
   input  logic [sat_pkg::COORD_W-1:0]      op_b,
   output logic [2*sat_pkg::COORD_W-1:0]    prod
);

   logic [2*sat_pkg::COORD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/sat_div.sv -----
// Restoring divider, one quotient bit a cycle; a quotient of 2^32 or more is flagged as capped.
`timescale 1ns / 1ps

module sat_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [sat_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [sat_pkg::LEN_W-1:0]          divisor,
   output logic [sat_pkg::QUOT_W-1:0]         quotient,
   output sat_pkg::div_stat_type              stat
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_CHECK,
      D_STEP
   } state_type;

   localparam int HI_W  = sat_pkg::DIVIDEND_W - sat_pkg::QUOT_W;
   localparam int CNT_W = $clog2(sat_pkg::QUOT_W);

   state_type                          state_ff;
   logic [sat_pkg::DIVIDEND_W-1:0]     num_ff;
   logic [sat_pkg::LEN_W-1:0]          den_ff;
   logic [sat_pkg::LEN_W-1:0]          rem_ff;
   logic [sat_pkg::QUOT_W-1:0]         low_ff;
   logic [sat_pkg::QUOT_W-1:0]         quot_ff;
   logic [CNT_W-1:0]                   cnt_ff;
   logic                               done_ff;
   logic                               capped_ff;

   logic [HI_W-1:0]                    num_hi;
   logic                               hi_too_big;
   logic [sat_pkg::LEN_W:0]            trial;
   logic [sat_pkg::LEN_W:0]            diff;
   logic                               take;
   logic [sat_pkg::LEN_W-1:0]          rem_in;

   assign num_hi     = num_ff[sat_pkg::DIVIDEND_W-1:sat_pkg::QUOT_W];
   // quotient reaches 2^32 exactly when the upper dividend bits reach the divisor
   assign hi_too_big = {{(sat_pkg::LEN_W-HI_W){1'b0}}, num_hi} >= den_ff;
   assign trial      = {rem_ff, low_ff[sat_pkg::QUOT_W-1]};
   assign take       = trial >= {1'b0, den_ff};
   assign diff       = trial - {1'b0, den_ff};
   assign rem_in     = take ? diff[sat_pkg::LEN_W-1:0] : trial[sat_pkg::LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= D_IDLE;
         done_ff   <= 1'b0;
         capped_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            D_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  num_ff   <= dividend;
                  den_ff   <= divisor;
                  state_ff <= D_CHECK;
               end
            end
            D_CHECK: begin
               if (hi_too_big) begin
                  capped_ff <= 1'b1;
                  done_ff   <= 1'b1;
                  state_ff  <= D_IDLE;
               end else begin
                  capped_ff <= 1'b0;
                  rem_ff    <= {{(sat_pkg::LEN_W-HI_W){1'b0}}, num_hi};
                  low_ff    <= num_ff[sat_pkg::QUOT_W-1:0];
                  cnt_ff    <= '0;
                  state_ff  <= D_STEP;
               end
            end
            D_STEP: begin
               rem_ff  <= rem_in;
               low_ff  <= {low_ff[sat_pkg::QUOT_W-2:0], 1'b0};
               quot_ff <= {quot_ff[sat_pkg::QUOT_W-2:0], take};
               cnt_ff  <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(sat_pkg::QUOT_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign quotient    = quot_ff;
   assign stat.done   = done_ff;
   assign stat.capped = capped_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == D_IDLE)
      else $error("divider started while busy");

   a_cap_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_CHECK && hi_too_big) |=> (done_ff && capped_ff))
      else $error("overflowing quotient not reported as capped");

endmodule

// ----- hw/rtl/sat_axis_mtv_tracker.sv -----
// Separating-axis test with minimum translation vector tracking, top level.
// A degenerate or separated axis goes from request through the length and check steps to
// the result; an overlapping one also divides each component, skipping the divide steps
// where a quotient overflows. One request in flight, so no new request is taken until
// the result is issued. The 32-step restoring divider, once per component, sets the rate.
// Reset (synchronous) clears the kept vector to zero, its length to all ones, threshold to 1.
`timescale 1ns / 1ps

module sat_axis_mtv_tracker (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write_en,
   input  logic [31:0]                   csr_write_data,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_start_req,
   input  logic signed [31:0]            req_axis_x,
   input  logic signed [31:0]            req_axis_y,
   input  logic signed [31:0]            req_axis_z,
   input  logic signed [31:0]            req_min_first,
   input  logic signed [31:0]            req_max_first,
   input  logic signed [31:0]            req_min_second,
   input  logic signed [31:0]            req_max_second,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_overlaps,
   output logic signed [31:0]            rsp_mtv_x,
   output logic signed [31:0]            rsp_mtv_y,
   output logic signed [31:0]            rsp_mtv_z,
   output logic [63:0]                   rsp_mtv_length_sq
);

   localparam int CW = sat_pkg::COORD_W;
   localparam int LW = sat_pkg::LEN_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEN,
      S_CHECK,
      S_PMUL,
      S_PWAIT,
      S_DIV,
      S_SMUL,
      S_SWAIT,
      S_UPD,
      S_FIN
   } state_type;

   localparam logic [CW-1:0] POS_LIMIT = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] NEG_LIMIT = {1'b1, {(CW-1){1'b0}}};

   state_type               state_ff;
   logic [1:0]              cnt_ff;
   logic [1:0]              comp_ff;
   logic [31:0]             thr_ff;
   logic [CW-1:0]           ax_ff [3];
   logic [CW-1:0]           min_a_ff;
   logic [CW-1:0]           max_a_ff;
   logic [CW-1:0]           min_b_ff;
   logic [CW-1:0]           max_b_ff;
   logic [LW-1:0]           len_ff;
   logic [LW-1:0]           csq_ff;
   logic [CW-1:0]           omag_ff;
   logic                    ovneg_ff;
   logic                    ovl_ff;
   logic [CW-1:0]           cand_ff [3];
   logic [CW-1:0]           magc_ff;
   logic [CW-1:0]           best_vec_ff [3];
   logic [LW-1:0]           best_len_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_overlaps_ff;
   logic [CW-1:0]           rsp_mtv_ff [3];
   logic [LW-1:0]           rsp_len_ff;

   logic [1:0]              sel_idx;
   logic [CW-1:0]           ax_sel;
   logic [CW-1:0]           mul_a;
   logic [CW-1:0]           mul_b;
   logic [2*CW-1:0]         prod;
   logic                    div_start;
   logic [sat_pkg::QUOT_W-1:0] div_quot;
   sat_pkg::div_stat_type   div_stat;

   logic signed [CW:0]      d0;
   logic signed [CW:0]      d1;
   logic                    degenerate;
   logic                    separated;
   logic                    take_left;
   logic                    neg_c;
   logic [CW-1:0]           magc_in;
   logic [CW-1:0]           cand_in;
   logic                    better;
   logic                    accept;
   logic                    rsp_free;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign sel_idx = (state_ff == S_LEN) ? ((cnt_ff == 2'd3) ? 2'd2 : cnt_ff) : comp_ff;
   assign ax_sel  = ax_ff[sel_idx];

   always_comb begin
      mul_a = sat_pkg::mag32(ax_sel);
      mul_b = mul_a;
      case (state_ff)
         S_PMUL: mul_b = omag_ff;
         S_SMUL: begin
            mul_a = magc_ff;
            mul_b = magc_ff;
         end
         default: ;
      endcase
   end

   sat_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign div_start = (state_ff == S_PWAIT);

   sat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({prod[2*CW-2:0], 16'd0}),
      .divisor  (len_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // interval penetrations, exact in 33 bits
   assign d0 = {max_b_ff[CW-1], max_b_ff} - {min_a_ff[CW-1], min_a_ff};
   assign d1 = {max_a_ff[CW-1], max_a_ff} - {min_b_ff[CW-1], min_b_ff};
   assign degenerate = (len_ff < {32'd0, thr_ff}) || (len_ff == '0);
   assign separated  = d0[CW] || (d0 == '0) || d1[CW] || (d1 == '0);
   assign take_left  = d0 < d1;

   // saturate the quotient into the signed component range
   assign neg_c = ax_sel[CW-1] ^ ovneg_ff;
   always_comb begin
      if (neg_c) begin
         magc_in = (div_stat.capped || div_quot > NEG_LIMIT) ? NEG_LIMIT : div_quot;
         cand_in = ~magc_in + CW'(1);
      end else begin
         magc_in = (div_stat.capped || div_quot > POS_LIMIT) ? POS_LIMIT : div_quot;
         cand_in = magc_in;
      end
   end

   assign better = csq_ff < best_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= 32'd1;
         best_len_ff  <= '1;
         for (int i = 0; i < 3; i++) begin
            best_vec_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            thr_ff <= csr_write_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ax_ff[0] <= req_axis_x;
                  ax_ff[1] <= req_axis_y;
                  ax_ff[2] <= req_axis_z;
                  min_a_ff <= req_min_first;
                  max_a_ff <= req_max_first;
                  min_b_ff <= req_min_second;
                  max_b_ff <= req_max_second;
                  len_ff   <= '0;
                  cnt_ff   <= '0;
                  if (req_start_req) begin
                     best_len_ff <= '1;
                     for (int i = 0; i < 3; i++) begin
                        best_vec_ff[i] <= '0;
                     end
                  end
                  state_ff <= S_LEN;
               end
            end
            S_LEN: begin
               // issue one square a cycle, add the previous one
               if (cnt_ff != 2'd0) begin
                  len_ff <= len_ff + prod;
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               omag_ff  <= take_left ? d0[CW-1:0] : d1[CW-1:0];
               ovneg_ff <= !take_left;
               comp_ff  <= '0;
               csq_ff   <= '0;
               if (degenerate) begin
                  ovl_ff   <= 1'b1;
                  state_ff <= S_FIN;
               end else if (separated) begin
                  ovl_ff   <= 1'b0;
                  state_ff <= S_FIN;
               end else begin
                  ovl_ff   <= 1'b1;
                  state_ff <= S_PMUL;
               end
            end
            S_PMUL: state_ff <= S_PWAIT;
            S_PWAIT: state_ff <= S_DIV;
            S_DIV: begin
               if (div_stat.done) begin
                  cand_ff[comp_ff] <= cand_in;
                  magc_ff          <= magc_in;
                  state_ff         <= S_SMUL;
               end
            end
            S_SMUL: state_ff <= S_SWAIT;
            S_SWAIT: begin
               csq_ff <= csq_ff + prod;
               if (comp_ff == 2'd2) begin
                  state_ff <= S_UPD;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= S_PMUL;
               end
            end
            S_UPD: begin
               if (better) begin
                  best_len_ff <= csq_ff;
                  for (int i = 0; i < 3; i++) begin
                     best_vec_ff[i] <= cand_ff[i];
                  end
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // hold until the output register is free
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_overlaps_ff <= ovl_ff;
                  rsp_len_ff      <= best_len_ff;
                  for (int i = 0; i < 3; i++) begin
                     rsp_mtv_ff[i] <= best_vec_ff[i];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_overlaps      = rsp_overlaps_ff;
   assign rsp_mtv_x         = rsp_mtv_ff[0];
   assign rsp_mtv_y         = rsp_mtv_ff[1];
   assign rsp_mtv_z         = rsp_mtv_ff[2];
   assign rsp_mtv_length_sq = rsp_len_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside the finish step");

   a_empty_best_zero: assert property (@(posedge clock) disable iff (reset)
      (best_len_ff == '1) |->
         (best_vec_ff[0] == '0 && best_vec_ff[1] == '0 && best_vec_ff[2] == '0))
      else $error("kept vector not zero while no vector is kept");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

endmodule
